// ===== rtl/bit_deposit_extract_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bit deposit / extract unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BIT_DEPOSIT_EXTRACT_UNIT_MACROS_SVH
`define BIT_DEPOSIT_EXTRACT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define BDE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);
`else
`define BDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define BDE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit deposit / extract package
// Field widths, default data path width and operation codes.
// ----------------------------------------------------------------------------
package bde_pkg;

    // width of every data field on the ports
    localparam int BDE_WORD_WIDTH = 64;
    // default width of the internal data path
    localparam int BDE_DATA_WIDTH = 64;

    typedef enum logic {
        BDE_OP_DEPOSIT = 1'b0,
        BDE_OP_EXTRACT = 1'b1
    } op_t;

endpackage

// ===== rtl/bit_deposit_extract_unit.sv =====
// ----------------------------------------------------------------------------
// Bit deposit / extract unit
// Pipelined parallel bit deposit (scatter) and extract (gather) on one word.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel: s_axis_tdata carries the source
//   word (bits 63:0) and the select mask (bits 127:64); s_axis_tuser selects
//   the operation (0 = deposit, 1 = extract). Results leave on the m_axis
//   channel as one 64-bit word per item, in the order the items came in.
//   Only the low DATA_WIDTH bits of source and mask take part; result bits at
//   and above DATA_WIDTH are zero. A source or mask of all ones gives all ones.
//   From input acceptance to m_axis_tvalid, the accepting edge loads the
//   operand register, and the zero-count, gather and output registers
//   (scatter and result select feed the last) follow in that order. The unit
//   takes one item per cycle while the receiver keeps up, since each of the
//   four register stages passes one item per cycle.
//   Each stage advances when it is empty or its successor advances, so a
//   stalled receiver fills the bubbles first and then drops s_axis_tready;
//   nothing is lost or repeated. Reset clears all valid bits but not the
//   data registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "bit_deposit_extract_unit_macros.svh"

module bit_deposit_extract_unit
    import bde_pkg::*;
#(
    parameter int DATA_WIDTH = BDE_DATA_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [63:0] source_word, [127:64] select_mask
    input  logic [2*BDE_WORD_WIDTH-1:0]   s_axis_tdata,
    // [0] operation
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [63:0] result_word
    output logic [BDE_WORD_WIDTH-1:0]     m_axis_tdata
);

    localparam int LOG_W = $clog2(DATA_WIDTH);
    // a zero count never exceeds DATA_WIDTH - 1
    localparam int CNT_W = LOG_W;
    localparam logic [DATA_WIDTH-1:0]     DATA_ONES = {DATA_WIDTH{1'b1}};
    localparam logic [BDE_WORD_WIDTH-1:0] WORD_MASK = BDE_WORD_WIDTH'(DATA_ONES);

    // ------------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, out_ready;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s3_ready      = !s3_valid_reg || out_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;

    // ------------------------------------------------------------------------
    // Stage 1: capture operands, trim to the data path, flag void operands
    // ------------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] s1_src_reg, s1_sel_reg;
    op_t                   s1_op_reg;
    logic                  s1_void_reg;
    logic [DATA_WIDTH-1:0] in_src, in_sel;

    assign in_src = s_axis_tdata[0 +: DATA_WIDTH];
    assign in_sel = s_axis_tdata[BDE_WORD_WIDTH +: DATA_WIDTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
        if (s1_ready) begin
            s1_src_reg  <= in_src;
            s1_sel_reg  <= in_sel;
            s1_op_reg   <= op_t'(s_axis_tuser);
            s1_void_reg <= (in_src == DATA_ONES) || (in_sel == DATA_ONES);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: per bit, count the mask zeros below it (Kogge-Stone prefix).
    // That count is how far a selected bit travels in the gather.
    // ------------------------------------------------------------------------
    logic [CNT_W-1:0]      ks [LOG_W+1][DATA_WIDTH];
    logic [CNT_W-1:0]      s2_zcnt_reg [DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s2_src_reg, s2_sel_reg;
    op_t                   s2_op_reg;
    logic                  s2_void_reg;

    always_comb begin
        int sh;
        ks[0][0] = '0;
        for (int i = 1; i < DATA_WIDTH; i++) begin
            ks[0][i] = {{(CNT_W-1){1'b0}}, ~s1_sel_reg[i-1]};
        end
        for (int l = 0; l < LOG_W; l++) begin
            sh = 1 << l;
            for (int i = 0; i < DATA_WIDTH; i++) begin
                ks[l+1][i] = ks[l][i];
                if (i >= sh) begin
                    ks[l+1][i] = ks[l][i] + ks[l][i-sh];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s2_ready) begin
            s2_zcnt_reg <= ks[LOG_W];
            s2_src_reg  <= s1_src_reg;
            s2_sel_reg  <= s1_sel_reg;
            s2_op_reg   <= s1_op_reg;
            s2_void_reg <= s1_void_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: gather network. At level j a selected bit moves down by 2^j
    // when bit j of its zero count is set; smallest moves first keeps the
    // bits from colliding. The move masks of each level are kept for the
    // scatter, which runs the same network backwards.
    // ------------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] occ [LOG_W+1];
    logic [DATA_WIDTH-1:0] dat [LOG_W+1];
    logic [CNT_W-1:0]      tag [LOG_W+1][DATA_WIDTH];
    logic [DATA_WIDTH-1:0] move [LOG_W];
    logic                  collide;

    logic [DATA_WIDTH-1:0] s3_move_reg [LOG_W];
    logic [DATA_WIDTH-1:0] s3_ext_reg, s3_src_reg, s3_sel_reg;
    op_t                   s3_op_reg;
    logic                  s3_void_reg;

    always_comb begin
        int   sh;
        logic stay_b, from_hi;
        occ[0]  = s2_sel_reg;
        dat[0]  = s2_src_reg;
        tag[0]  = s2_zcnt_reg;
        collide = 1'b0;
        for (int j = 0; j < LOG_W; j++) begin
            sh = 1 << j;
            for (int i = 0; i < DATA_WIDTH; i++) begin
                stay_b     = occ[j][i] && !tag[j][i][j];
                move[j][i] = occ[j][i] && tag[j][i][j];
                from_hi    = 1'b0;
                if (i + sh < DATA_WIDTH) begin
                    from_hi = occ[j][i+sh] && tag[j][i+sh][j];
                end
                collide       = collide || (stay_b && from_hi);
                occ[j+1][i]   = stay_b || from_hi;
                tag[j+1][i]   = tag[j][i];
                dat[j+1][i]   = dat[j][i];
                if (from_hi) begin
                    tag[j+1][i] = tag[j][i+sh];
                    dat[j+1][i] = dat[j][i+sh];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (s3_ready) begin
            s3_move_reg <= move;
            // drop the leftovers above the packed bits
            s3_ext_reg  <= dat[LOG_W] & occ[LOG_W];
            s3_src_reg  <= s2_src_reg;
            s3_sel_reg  <= s2_sel_reg;
            s3_op_reg   <= s2_op_reg;
            s3_void_reg <= s2_void_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: scatter network (largest move first, upward), then select the
    // result and hold it in the output register.
    // ------------------------------------------------------------------------
    logic [DATA_WIDTH-1:0]     xp [LOG_W+1];
    logic [DATA_WIDTH-1:0]     dep_word, res_word;
    logic [BDE_WORD_WIDTH-1:0] out_data_reg;

    always_comb begin
        int sh;
        xp[LOG_W] = s3_src_reg;
        for (int j = LOG_W - 1; j >= 0; j--) begin
            sh = 1 << j;
            for (int i = 0; i < DATA_WIDTH; i++) begin
                xp[j][i] = xp[j+1][i];
                if (i >= sh) begin
                    if (s3_move_reg[j][i]) begin
                        xp[j][i] = xp[j+1][i-sh];
                    end
                end
            end
        end
        dep_word = xp[0] & s3_sel_reg;
    end

    always_comb begin
        if (s3_void_reg) begin
            res_word = DATA_ONES;
        end else if (s3_op_reg == BDE_OP_EXTRACT) begin
            res_word = s3_ext_reg;
        end else begin
            res_word = dep_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= s3_valid_reg;
        end
        if (out_ready) begin
            out_data_reg <= BDE_WORD_WIDTH'(res_word);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `BDE_ASSERT_NEVER(a_no_collide, aclk, aresetn, s2_valid_reg && collide,
        "gather network collision")
    `BDE_ASSERT_IMPLY(a_bits_kept, aclk, aresetn, s2_valid_reg,
        $countones(occ[LOG_W]) == $countones(s2_sel_reg), "gather lost or made bits")
    `BDE_ASSERT_IMPLY(a_high_zero, aclk, aresetn, out_valid_reg,
        (out_data_reg & ~WORD_MASK) == '0, "result bits above data path set")
    `BDE_ASSERT_IMPLY(a_full_stall, aclk, aresetn,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg && !m_axis_tready,
        !s_axis_tready, "input accepted into a full stalled pipe")

endmodule
